// File: src/order_book_matcher_macros.svh
// Assertion macros shared by the order book matcher checker.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ORDER_BOOK_MATCHER_MACROS_SVH
`define ORDER_BOOK_MATCHER_MACROS_SVH

// Same-cycle implication
`define OBM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define OBM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/obm_pkg.sv
// Shared types and constants for the order book matcher.
// No dependencies.
package obm_pkg;

    localparam int BOOK_DEPTH_DEF = 16;
    localparam int MAX_RESULTS    = 16;
    localparam int RES_CNT_W      = $clog2(MAX_RESULTS + 1);
    localparam int SLOT_W         = 4;

    localparam logic ACT_BUY  = 1'b0;
    localparam logic ACT_SELL = 1'b1;

    typedef enum logic [1:0] {
        KIND_TRADE  = 2'd0,
        KIND_BOOKED = 2'd1,
        KIND_REJECT = 2'd2
    } t_kind;

    typedef struct packed {
        logic        action;
        logic [15:0] symbol;
        logic [31:0] price;
        logic [31:0] quantity;
    } t_order;

    typedef struct packed {
        t_kind              kind;
        logic [15:0]        trade_symbol;
        logic [31:0]        trade_quantity;
        logic [32:0]        price_sum;
        logic [SLOT_W-1:0]  buy_slot;
        logic [SLOT_W-1:0]  sell_slot;
        logic               last;
    } t_result;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic find;
        logic insert;
        logic skip;
        logic eval;
        logic trade;
        logic fin;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic side_full;
        logic scan_done;
        logic cur_active;
        logic match_any;
        logic pend_valid;
        logic out_free;
    } t_status;

endpackage

// File: src/order_book_matcher.sv
// Steps: accept, find the insert slot, book the order, then scan the buy side,
// skip inactive entries, match active ones against all sells, then finish.
// One order at a time: the input stalls until the finish. A side-full reject
// skips to the finish. Output waits in a register under stall.
// Reset (synchronous, active low) empties both book sides and drops any result.
// Contains obm_ctrl and obm_datapath; depends on obm_pkg.
module order_book_matcher import obm_pkg::*; #(
    parameter int BOOK_DEPTH = BOOK_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_ord_valid,
    output logic    o_ord_stall,
    input  t_order  i_ord,
    output logic    o_res_valid,
    input  logic    i_res_stall,
    output t_result o_res
);

    t_cmd    w_cmd;
    t_status w_sts;

    obm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ord_valid (i_ord_valid),
        .o_ord_stall (o_ord_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    obm_datapath #(
        .BOOK_DEPTH (BOOK_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ord       (i_ord),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_res_valid (o_res_valid),
        .i_res_stall (i_res_stall),
        .o_res       (o_res)
    );

endmodule

// File: src/obm_ctrl.sv
// Sequencer for the order book matcher: accept, find, insert, matching scan, finish.
// Depends on obm_pkg.
module obm_ctrl import obm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_ord_valid,
    output logic    o_ord_stall,
    input  t_status i_sts,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_FIND, S_INS, S_SCAN, S_TRADE, S_FINAL
    } t_state;

    t_state r_state, n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_ord_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = i_sts.side_full ? S_FINAL : S_FIND;
                end
            end
            S_FIND: begin
                o_cmd.find = 1'b1;
                n_state = S_INS;
            end
            S_INS: begin
                o_cmd.insert = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_FINAL;
                end else if (!i_sts.cur_active) begin
                    o_cmd.skip = 1'b1;
                end else begin
                    o_cmd.eval = 1'b1;
                    n_state = S_TRADE;
                end
            end
            S_TRADE: begin
                if (!i_sts.match_any) begin
                    o_cmd.skip = 1'b1;
                    n_state = S_SCAN;
                end else if (!i_sts.pend_valid || i_sts.out_free) begin
                    o_cmd.trade = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_FINAL: begin
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ord_stall = (r_state != S_IDLE);

endmodule

// File: src/obm_datapath.sv
// Book storage, insertion shifter, parallel sell compare, trade arithmetic
// and output register. Depends on obm_pkg.
module obm_datapath import obm_pkg::*; #(
    parameter int BOOK_DEPTH = BOOK_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_order  i_ord,
    input  t_cmd    i_cmd,
    output t_status o_sts,
    output logic    o_res_valid,
    input  logic    i_res_stall,
    output t_result o_res
);

    localparam int IW = $clog2(BOOK_DEPTH);
    localparam int CW = $clog2(BOOK_DEPTH + 1);

    logic [31:0] r_buy_price  [BOOK_DEPTH];
    logic [31:0] r_buy_qty    [BOOK_DEPTH];
    logic [15:0] r_buy_sym    [BOOK_DEPTH];
    logic [BOOK_DEPTH-1:0] r_buy_act;
    logic [CW-1:0] r_buy_cnt;
    logic [31:0] r_sell_price [BOOK_DEPTH];
    logic [31:0] r_sell_qty   [BOOK_DEPTH];
    logic [15:0] r_sell_sym   [BOOK_DEPTH];
    logic [BOOK_DEPTH-1:0] r_sell_act;
    logic [CW-1:0] r_sell_cnt;

    t_order                r_ord;
    logic [BOOK_DEPTH-1:0] r_flags;
    logic [BOOK_DEPTH-1:0] r_match;
    logic [CW-1:0]         r_i;
    logic [RES_CNT_W-1:0]  r_n;
    t_result               r_pend;
    logic                  r_pend_v;
    t_result               r_out;
    logic                  r_out_v;

    logic                  w_is_sell;
    logic [CW-1:0]         w_cnt;
    logic [BOOK_DEPTH-1:0] w_flags;
    logic [BOOK_DEPTH-1:0] w_ge;
    logic [BOOK_DEPTH-1:0] w_eq;
    logic [IW-1:0]         w_bi;
    logic [BOOK_DEPTH-1:0] w_match;
    logic [BOOK_DEPTH-1:0] w_mge;
    logic [BOOK_DEPTH-1:0] w_sel;
    logic [IW-1:0]         w_j;
    logic [31:0]           w_sp;
    logic [31:0]           w_sq;
    logic [31:0]           w_bq;
    logic [31:0]           w_t;
    logic [IW+SLOT_W-1:0]  w_bext;
    logic [IW+SLOT_W-1:0]  w_sext;
    t_result               w_trade_res;
    t_result               w_emit_res;
    logic                  w_emit;
    logic                  w_out_free;

    assign w_is_sell  = (r_ord.action == ACT_SELL);
    assign w_cnt      = w_is_sell ? r_sell_cnt : r_buy_cnt;
    assign w_bi       = r_i[IW-1:0];
    assign w_out_free = !r_out_v || !i_res_stall;

    // Status to the controller
    always_comb begin
        o_sts.side_full  = (i_ord.action == ACT_SELL) ? (r_sell_cnt == CW'(BOOK_DEPTH))
                                                       : (r_buy_cnt == CW'(BOOK_DEPTH));
        o_sts.scan_done  = (r_i >= r_buy_cnt) || (r_n == RES_CNT_W'(MAX_RESULTS));
        o_sts.cur_active = r_buy_act[w_bi];
        o_sts.match_any  = |r_match;
        o_sts.pend_valid = r_pend_v;
        o_sts.out_free   = w_out_free;
    end

    // Insert position candidates: head goes only on a strictly better price
    always_comb begin
        for (int k = 0; k < BOOK_DEPTH; k++) begin
            logic [31:0] pr;
            pr = w_is_sell ? r_sell_price[k] : r_buy_price[k];
            if (k == 0) begin
                w_flags[k] = (w_cnt == '0) ||
                             (w_is_sell ? (r_ord.price < pr) : (r_ord.price > pr));
            end else begin
                w_flags[k] = (CW'(k) >= w_cnt) ||
                             (w_is_sell ? (pr >= r_ord.price) : (pr <= r_ord.price));
            end
        end
    end

    // First set flag marks the slot; everything past it shifts down
    always_comb begin
        w_ge[0] = r_flags[0];
        w_eq[0] = r_flags[0];
        for (int k = 1; k < BOOK_DEPTH; k++) begin
            w_ge[k] = w_ge[k-1] | r_flags[k];
            w_eq[k] = r_flags[k] & !w_ge[k-1];
        end
    end

    // Current buy against all sells
    always_comb begin
        for (int k = 0; k < BOOK_DEPTH; k++) begin
            w_match[k] = r_sell_act[k] && (r_sell_sym[k] == r_buy_sym[w_bi]) &&
                         (r_sell_price[k] <= r_buy_price[w_bi]);
        end
    end

    // First matching sell
    always_comb begin
        w_mge[0] = r_match[0];
        w_sel[0] = r_match[0];
        for (int k = 1; k < BOOK_DEPTH; k++) begin
            w_mge[k] = w_mge[k-1] | r_match[k];
            w_sel[k] = r_match[k] & !w_mge[k-1];
        end
        w_j  = '0;
        w_sp = '0;
        w_sq = '0;
        for (int k = 0; k < BOOK_DEPTH; k++) begin
            if (w_sel[k]) begin
                w_j  = w_j | IW'(k);
                w_sp = w_sp | r_sell_price[k];
                w_sq = w_sq | r_sell_qty[k];
            end
        end
    end

    // Trade arithmetic
    always_comb begin
        w_bq   = r_buy_qty[w_bi];
        w_t    = (w_sq < w_bq) ? w_sq : w_bq;
        w_bext = (IW+SLOT_W)'(w_bi);
        w_sext = (IW+SLOT_W)'(w_j);
        w_trade_res.kind           = KIND_TRADE;
        w_trade_res.trade_symbol   = r_buy_sym[w_bi];
        w_trade_res.trade_quantity = w_t;
        w_trade_res.price_sum      = {1'b0, r_buy_price[w_bi]} + {1'b0, w_sp};
        w_trade_res.buy_slot       = w_bext[SLOT_W-1:0];
        w_trade_res.sell_slot      = w_sext[SLOT_W-1:0];
        w_trade_res.last           = 1'b0;
    end

    // Result emission: a held trade goes out when the next one appears or at the end
    always_comb begin
        w_emit     = 1'b0;
        w_emit_res = r_pend;
        if (i_cmd.trade && r_pend_v) begin
            w_emit = 1'b1;
            w_emit_res.last = 1'b0;
        end else if (i_cmd.fin) begin
            w_emit = 1'b1;
            if (!r_pend_v) begin
                w_emit_res      = '0;
                w_emit_res.kind = KIND_BOOKED;
            end
            w_emit_res.last = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buy_act  <= '0;
            r_sell_act <= '0;
            r_buy_cnt  <= '0;
            r_sell_cnt <= '0;
            r_pend_v   <= 1'b0;
            r_out_v    <= 1'b0;
            r_i        <= '0;
            r_n        <= '0;
        end else begin
            if (i_cmd.accept && o_sts.side_full) begin
                r_pend_v <= 1'b1;
            end
            if (i_cmd.insert) begin
                r_i      <= '0;
                r_n      <= '0;
                r_pend_v <= 1'b0;
                if (w_is_sell) begin
                    r_sell_cnt <= r_sell_cnt + 1'b1;
                    for (int k = 1; k < BOOK_DEPTH; k++) begin
                        if (w_ge[k] && !w_eq[k]) r_sell_act[k] <= r_sell_act[k-1];
                    end
                    for (int k = 0; k < BOOK_DEPTH; k++) begin
                        if (w_eq[k]) r_sell_act[k] <= 1'b1;
                    end
                end else begin
                    r_buy_cnt <= r_buy_cnt + 1'b1;
                    for (int k = 1; k < BOOK_DEPTH; k++) begin
                        if (w_ge[k] && !w_eq[k]) r_buy_act[k] <= r_buy_act[k-1];
                    end
                    for (int k = 0; k < BOOK_DEPTH; k++) begin
                        if (w_eq[k]) r_buy_act[k] <= 1'b1;
                    end
                end
            end
            if (i_cmd.skip) begin
                r_i <= r_i + 1'b1;
            end
            if (i_cmd.trade) begin
                r_i      <= r_i + 1'b1;
                r_n      <= r_n + 1'b1;
                r_pend_v <= 1'b1;
                if (w_sq <= w_bq) r_sell_act[w_j] <= 1'b0;
                if (w_bq <= w_sq) r_buy_act[w_bi] <= 1'b0;
            end
            if (i_cmd.fin) begin
                r_pend_v <= 1'b0;
            end
            // Output register handshake
            if (w_emit) begin
                r_out_v <= 1'b1;
            end else if (!i_res_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_ord  <= i_ord;
            r_pend <= t_result'{kind: KIND_REJECT, default: '0};
        end
        if (i_cmd.find) begin
            r_flags <= w_flags;
        end
        if (i_cmd.eval) begin
            r_match <= w_match;
        end
        if (i_cmd.insert) begin
            if (w_is_sell) begin
                for (int k = 1; k < BOOK_DEPTH; k++) begin
                    if (w_ge[k] && !w_eq[k]) begin
                        r_sell_price[k] <= r_sell_price[k-1];
                        r_sell_qty[k]   <= r_sell_qty[k-1];
                        r_sell_sym[k]   <= r_sell_sym[k-1];
                    end
                end
                for (int k = 0; k < BOOK_DEPTH; k++) begin
                    if (w_eq[k]) begin
                        r_sell_price[k] <= r_ord.price;
                        r_sell_qty[k]   <= r_ord.quantity;
                        r_sell_sym[k]   <= r_ord.symbol;
                    end
                end
            end else begin
                for (int k = 1; k < BOOK_DEPTH; k++) begin
                    if (w_ge[k] && !w_eq[k]) begin
                        r_buy_price[k] <= r_buy_price[k-1];
                        r_buy_qty[k]   <= r_buy_qty[k-1];
                        r_buy_sym[k]   <= r_buy_sym[k-1];
                    end
                end
                for (int k = 0; k < BOOK_DEPTH; k++) begin
                    if (w_eq[k]) begin
                        r_buy_price[k] <= r_ord.price;
                        r_buy_qty[k]   <= r_ord.quantity;
                        r_buy_sym[k]   <= r_ord.symbol;
                    end
                end
            end
        end
        if (i_cmd.trade) begin
            r_buy_qty[w_bi] <= w_bq - w_t;
            r_sell_qty[w_j] <= w_sq - w_t;
            r_pend          <= w_trade_res;
        end
        if (w_emit) begin
            r_out <= w_emit_res;
        end
    end

    assign o_res_valid = r_out_v;
    assign o_res       = r_out;

endmodule

// File: src/obm_checker.sv
// Port-level checks for order_book_matcher, attached by bind.
// Depends on obm_pkg and order_book_matcher_macros.svh.
`include "order_book_matcher_macros.svh"

module obm_checker import obm_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_ord_valid,
    input logic    o_ord_stall,
    input t_order  i_ord,
    input logic    o_res_valid,
    input logic    i_res_stall,
    input t_result o_res
);

    // Stalled output transaction holds
    `OBM_ASSERT_NEXT(a_res_hold, o_res_valid && i_res_stall, o_res_valid && $stable(o_res), "result dropped or changed under stall")
    // Stalled input transaction holds
    `OBM_ASSERT_NEXT(a_ord_hold, i_ord_valid && o_ord_stall, i_ord_valid && $stable(i_ord), "order changed under stall")
    // An accepted order keeps the block busy next cycle
    `OBM_ASSERT_NEXT(a_busy_after_accept, i_ord_valid && !o_ord_stall, o_ord_stall, "input not stalled after accept")
    // Booked or rejected results are always the final one
    `OBM_ASSERT_NOW(a_nontrade_last, o_res_valid && o_res.kind != KIND_TRADE, o_res.last, "non-trade result without last")
    // Non-trade results carry zero trade fields
    `OBM_ASSERT_NOW(a_nontrade_zero, o_res_valid && o_res.kind != KIND_TRADE, o_res.trade_quantity == '0 && o_res.price_sum == '0 && o_res.trade_symbol == '0, "non-trade result with trade data")

endmodule

bind order_book_matcher obm_checker u_obm_checker (.*);
